>>> src/isll_pkg.sv
`default_nettype none

package isll_pkg;

   // Item numbers and the successor table
   localparam int ITEM_W  = 8;
   localparam int DEPTH   = 1 << ITEM_W;
   localparam int LIMIT_W = 16;

   // Operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_GET    = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   typedef logic [ITEM_W-1:0] item_type;

   // Write request into the successor table
   typedef struct packed {
      logic     we;
      item_type addr;
      item_type data;
   } succ_wr_type;

endpackage

`default_nettype wire

>>> src/isll_succ_mem.sv
`default_nettype none

module isll_succ_mem (
   input  wire logic                 clock,
   input  wire isll_pkg::succ_wr_type wr,
   input  wire isll_pkg::item_type    rd_addr,
   output isll_pkg::item_type         rd_data
);

   isll_pkg::item_type mem [isll_pkg::DEPTH];
   isll_pkg::item_type rd_data_ff;

   // Write one entry per cycle
   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Registered read: data appears in the cycle after the address
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/indexed_singly_linked_list.sv
`default_nettype none

// Singly linked list over item numbers 1..MAX_ITEMS, kept in a successor table.
// Command channel: a transaction is taken at a clock edge where start is high
// and busy is low; req_operation selects insert after, remove next, get at
// position or clear. Busy stays high from that edge until the result shows.
// Result channel: rsp_valid is high for exactly one cycle with rsp_modified,
// rsp_found_item and the head and tail after the operation; the receiver
// cannot stall it, and busy is already low in that cycle so the next command
// may be taken there.
// Clear, refused commands, insert at the front, get on an empty list and get
// at positions 0 and 1 end in S_DECIDE; removing the first item goes on
// through S_RM_HEAD, insert after a member through S_INS_LINK and
// S_INS_HOOK, remove after a member through S_RM_VICT and S_RM_LINK, and get
// at position p >= 2 follows links from the head in S_WALK until it reaches
// position p or the end of the list. These steps come from the successor
// memory, with a registered read and one write per cycle. The block takes one
// command at a time. Reset clears head, tail and the membership bits; the
// block is idle after reset and can take a command.

module indexed_singly_linked_list #(
   parameter int unsigned MAX_ITEMS = 255
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_operation,
   input  wire logic [isll_pkg::ITEM_W-1:0]   req_item,
   input  wire logic [isll_pkg::ITEM_W-1:0]   req_after,
   input  wire logic [isll_pkg::ITEM_W-1:0]   req_position,
   output logic                               rsp_valid,
   output logic                               rsp_modified,
   output logic [isll_pkg::ITEM_W-1:0]        rsp_found_item,
   output logic [isll_pkg::ITEM_W-1:0]        rsp_first_item,
   output logic [isll_pkg::ITEM_W-1:0]        rsp_last_item
);

   localparam logic [isll_pkg::LIMIT_W-1:0] ITEM_LIMIT = isll_pkg::LIMIT_W'(MAX_ITEMS);

   // Sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECIDE   = 3'd1;
   localparam logic [2:0] S_INS_LINK = 3'd2;
   localparam logic [2:0] S_INS_HOOK = 3'd3;
   localparam logic [2:0] S_RM_HEAD  = 3'd4;
   localparam logic [2:0] S_RM_VICT  = 3'd5;
   localparam logic [2:0] S_RM_LINK  = 3'd6;
   localparam logic [2:0] S_WALK     = 3'd7;

   logic [2:0]                   state_ff, state_in;
   logic [isll_pkg::DEPTH-1:0]   in_list_ff, in_list_in;
   isll_pkg::item_type           head_ff, head_in;
   isll_pkg::item_type           tail_ff, tail_in;
   logic [1:0]                   op_ff, op_in;
   isll_pkg::item_type           item_ff, item_in;
   isll_pkg::item_type           after_ff, after_in;
   isll_pkg::item_type           pos_ff, pos_in;
   isll_pkg::item_type           victim_ff, victim_in;
   isll_pkg::item_type           count_ff, count_in;
   logic                         valid_ff, valid_in;
   logic                         modified_ff, modified_in;
   isll_pkg::item_type           found_ff, found_in;

   isll_pkg::succ_wr_type        mem_wr;
   isll_pkg::item_type           mem_raddr;
   isll_pkg::item_type           mem_rdata;

   logic                         accept;
   logic                         item_out_of_range;

   isll_succ_mem u_succ_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign busy           = (state_ff != S_IDLE);
   assign accept         = start && !busy;
   assign rsp_valid      = valid_ff;
   assign rsp_modified   = modified_ff;
   assign rsp_found_item = found_ff;
   assign rsp_first_item = head_ff;
   assign rsp_last_item  = tail_ff;

   assign item_out_of_range = (item_ff == '0) ||
      ({{(isll_pkg::LIMIT_W - isll_pkg::ITEM_W){1'b0}}, item_ff} > ITEM_LIMIT);

   // Sequence one command through the successor table
   always_comb begin
      state_in    = state_ff;
      in_list_in  = in_list_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      op_in       = op_ff;
      item_in     = item_ff;
      after_in    = after_ff;
      pos_in      = pos_ff;
      victim_in   = victim_ff;
      count_in    = count_ff;
      valid_in    = 1'b0;
      modified_in = modified_ff;
      found_in    = found_ff;
      mem_wr      = '{we: 1'b0, addr: item_ff, data: head_ff};
      mem_raddr   = head_ff;

      case (state_ff)
         S_IDLE: begin
            // Capture the transaction
            if (accept) begin
               op_in    = req_operation;
               item_in  = req_item;
               after_in = req_after;
               pos_in   = req_position;
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            modified_in = 1'b0;
            found_in    = '0;
            case (op_ff)
               isll_pkg::OP_INSERT: begin
                  if (item_out_of_range || in_list_ff[item_ff] ||
                      (after_ff != '0 && !in_list_ff[after_ff])) begin
                     valid_in = 1'b1;
                     state_in = S_IDLE;
                  end else if (after_ff == '0) begin
                     // Link in at the front
                     mem_wr              = '{we: 1'b1, addr: item_ff, data: head_ff};
                     in_list_in[item_ff] = 1'b1;
                     head_in             = item_ff;
                     if (head_ff == '0) begin
                        tail_in = item_ff;
                     end
                     modified_in = 1'b1;
                     valid_in    = 1'b1;
                     state_in    = S_IDLE;
                  end else begin
                     mem_raddr = after_ff;
                     state_in  = S_INS_LINK;
                  end
               end

               isll_pkg::OP_REMOVE: begin
                  if (head_ff == '0 || item_ff == tail_ff ||
                      (item_ff != '0 && !in_list_ff[item_ff])) begin
                     valid_in = 1'b1;
                     state_in = S_IDLE;
                  end else if (item_ff == '0) begin
                     victim_in = head_ff;
                     mem_raddr = head_ff;
                     state_in  = S_RM_HEAD;
                  end else begin
                     mem_raddr = item_ff;
                     state_in  = S_RM_VICT;
                  end
               end

               isll_pkg::OP_GET: begin
                  if (pos_ff == '0) begin
                     valid_in = 1'b1;
                     state_in = S_IDLE;
                  end else if (pos_ff == isll_pkg::ITEM_W'(1) || head_ff == '0) begin
                     found_in = head_ff;
                     valid_in = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     // Start the walk from the head
                     mem_raddr = head_ff;
                     count_in  = isll_pkg::ITEM_W'(2);
                     state_in  = S_WALK;
                  end
               end

               isll_pkg::OP_CLEAR: begin
                  // Drop every member; stale successors are never read
                  modified_in = (head_ff != '0);
                  in_list_in  = '0;
                  head_in     = '0;
                  tail_in     = '0;
                  valid_in    = 1'b1;
                  state_in    = S_IDLE;
               end

               default: begin
                  valid_in = 1'b1;
                  state_in = S_IDLE;
               end
            endcase
         end

         S_INS_LINK: begin
            // New item takes over the successor of its predecessor
            mem_wr   = '{we: 1'b1, addr: item_ff, data: mem_rdata};
            state_in = S_INS_HOOK;
         end

         S_INS_HOOK: begin
            mem_wr              = '{we: 1'b1, addr: after_ff, data: item_ff};
            in_list_in[item_ff] = 1'b1;
            if (tail_ff == after_ff) begin
               tail_in = item_ff;
            end
            modified_in = 1'b1;
            valid_in    = 1'b1;
            state_in    = S_IDLE;
         end

         S_RM_HEAD: begin
            // Advance the head past the first item
            head_in               = mem_rdata;
            in_list_in[victim_ff] = 1'b0;
            if (tail_ff == victim_ff) begin
               tail_in = '0;
            end
            modified_in = 1'b1;
            valid_in    = 1'b1;
            state_in    = S_IDLE;
         end

         S_RM_VICT: begin
            victim_in = mem_rdata;
            mem_raddr = mem_rdata;
            state_in  = S_RM_LINK;
         end

         S_RM_LINK: begin
            // Bypass the victim
            mem_wr                = '{we: 1'b1, addr: item_ff, data: mem_rdata};
            in_list_in[victim_ff] = 1'b0;
            if (tail_ff == victim_ff) begin
               tail_in = item_ff;
            end
            modified_in = 1'b1;
            valid_in    = 1'b1;
            state_in    = S_IDLE;
         end

         S_WALK: begin
            // Follow one link per cycle
            if (count_ff == pos_ff || mem_rdata == '0) begin
               found_in = mem_rdata;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               mem_raddr = mem_rdata;
               count_in  = count_ff + isll_pkg::ITEM_W'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         in_list_ff <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         in_list_ff <= in_list_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         valid_ff   <= valid_in;
      end
   end

   // Command and result payload
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      item_ff     <= item_in;
      after_ff    <= after_in;
      pos_ff      <= pos_in;
      victim_ff   <= victim_in;
      count_ff    <= count_in;
      modified_ff <= modified_in;
      found_ff    <= found_in;
   end

   // Head and tail are empty together
   assert property (@(posedge clock) disable iff (reset)
      (head_ff == '0) == (tail_ff == '0))
      else $error("head and tail disagree on an empty list");

   // The tail is always a member
   assert property (@(posedge clock) disable iff (reset)
      (tail_ff != '0) |-> in_list_ff[tail_ff])
      else $error("tail is not marked as a member");

   // Item zero never becomes a member
   assert property (@(posedge clock) disable iff (reset)
      !in_list_ff[0])
      else $error("item zero marked as a member");

   // A result only ends a busy period
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a command in flight");

   // An accepted command makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("command accepted but block not busy");

endmodule

`default_nettype wire

>>> bench/indexed_singly_linked_list_test.sv
`default_nettype none

module indexed_singly_linked_list_test;

   localparam int IDLE_PCT   = 18;
   localparam int STALL_MAX  = 5000;
   localparam int DRAIN_WAIT = 300;
   localparam int N_RANDOM   = 700;

   typedef struct packed {
      logic               modified;
      isll_pkg::item_type found_item;
      isll_pkg::item_type first_item;
      isll_pkg::item_type last_item;
   } list_result_type;

   // Clock and stimulus, all known from time zero
   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               start         = 1'b0;
   logic [1:0]         req_operation = isll_pkg::OP_GET;
   isll_pkg::item_type req_item      = '0;
   isll_pkg::item_type req_after     = '0;
   isll_pkg::item_type req_position  = '0;

   wire logic               busy;
   wire logic               rsp_valid;
   wire logic               rsp_modified;
   wire isll_pkg::item_type rsp_found_item;
   wire isll_pkg::item_type rsp_first_item;
   wire isll_pkg::item_type rsp_last_item;

   // Shadow copy of the list
   isll_pkg::item_type shadow_next [isll_pkg::DEPTH];
   bit                 shadow_member [isll_pkg::DEPTH];
   isll_pkg::item_type shadow_head;
   isll_pkg::item_type shadow_tail;
   int                 shadow_len;

   list_result_type expected_q[$];
   bit   take_ok    = 1'b0;
   bit   idle_on    = 1'b1;
   int   fail_count = 0;
   int   checked    = 0;
   int   op_count [4];
   int   stall_cycles = 0;

   indexed_singly_linked_list #(.MAX_ITEMS(255)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_item       (req_item),
      .req_after      (req_after),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_modified   (rsp_modified),
      .rsp_found_item (rsp_found_item),
      .rsp_first_item (rsp_first_item),
      .rsp_last_item  (rsp_last_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one operation to the shadow list and return the result it yields
   function automatic list_result_type apply_list_op(logic [1:0] op,
                                                     isll_pkg::item_type it,
                                                     isll_pkg::item_type aft,
                                                     isll_pkg::item_type pos);
      list_result_type    r;
      isll_pkg::item_type cur;
      isll_pkg::item_type victim;
      int                 steps;
      r = '0;
      case (op)
         isll_pkg::OP_INSERT: begin
            if (it != 0 && !shadow_member[it] && (aft == 0 || shadow_member[aft])) begin
               if (aft == 0) begin
                  if (shadow_head == 0) shadow_tail = it;
                  shadow_next[it] = shadow_head;
                  shadow_head = it;
               end else begin
                  shadow_next[it] = shadow_next[aft];
                  shadow_next[aft] = it;
                  if (shadow_tail == aft) shadow_tail = it;
               end
               shadow_member[it] = 1'b1;
               shadow_len++;
               r.modified = 1'b1;
            end
         end
         isll_pkg::OP_REMOVE: begin
            if (shadow_head != 0 && it != shadow_tail && (it == 0 || shadow_member[it])) begin
               if (it == 0) begin
                  victim = shadow_head;
                  shadow_head = shadow_next[victim];
               end else begin
                  victim = shadow_next[it];
                  shadow_next[it] = shadow_next[victim];
               end
               if (shadow_tail == victim) shadow_tail = it;
               shadow_next[victim] = '0;
               shadow_member[victim] = 1'b0;
               shadow_len--;
               r.modified = 1'b1;
            end
         end
         isll_pkg::OP_GET: begin
            cur = shadow_head;
            if (pos == 0) cur = '0;
            for (steps = 1; steps < int'(pos) && cur != 0; steps++) cur = shadow_next[cur];
            r.found_item = cur;
         end
         default: begin
            r.modified = (shadow_head != 0);
            for (int i = 0; i < isll_pkg::DEPTH; i++) begin
               shadow_next[i] = '0;
               shadow_member[i] = 1'b0;
            end
            shadow_head = '0;
            shadow_tail = '0;
            shadow_len = 0;
         end
      endcase
      r.first_item = shadow_head;
      r.last_item = shadow_tail;
      return r;
   endfunction

   // Random member of the list, or 0 when it is empty
   function automatic isll_pkg::item_type pick_member();
      isll_pkg::item_type cur;
      int                 k;
      if (shadow_len == 0) return '0;
      k = $urandom_range(1, shadow_len);
      cur = shadow_head;
      for (int i = 1; i < k; i++) cur = shadow_next[cur];
      return cur;
   endfunction

   // Random item not in the list; may return a member if 4096 draws all hit members, as on a full list
   function automatic isll_pkg::item_type pick_free();
      isll_pkg::item_type c;
      c = isll_pkg::item_type'($urandom_range(1, 255));
      for (int tries = 0; tries < 4096 && shadow_member[c]; tries++)
         c = isll_pkg::item_type'($urandom_range(1, 255));
      return c;
   endfunction

   // Sample the command handshake mid-cycle, away from the clock edge
   always @(negedge clock) take_ok = !busy && !reset;

   // Send one transaction and queue its expected result
   task automatic send_op(logic [1:0] op, isll_pkg::item_type it,
                          isll_pkg::item_type aft, isll_pkg::item_type pos);
      while (idle_on && $urandom_range(0, 99) < IDLE_PCT) @(posedge clock);
      start <= 1'b1;
      req_operation <= op;
      req_item <= it;
      req_after <= aft;
      req_position <= pos;
      do @(posedge clock); while (!take_ok);
      expected_q.push_back(apply_list_op(op, it, aft, pos));
      op_count[op]++;
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   // Check every result strobe against the oldest expectation
   always @(negedge clock) begin
      list_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none actual modified=%0d found=%0d",
                     $time, rsp_modified, rsp_found_item);
            fail_count++;
         end else begin
            want = expected_q.pop_front();
            compare_field("modified", want.modified, rsp_modified);
            compare_field("found_item", want.found_item, rsp_found_item);
            compare_field("first_item", want.first_item, rsp_first_item);
            compare_field("last_item", want.last_item, rsp_last_item);
            checked++;
         end
      end
   end

   // Count cycles with no transaction in either direction
   always @(negedge clock) begin
      if (rsp_valid || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
   end

   initial begin
      while (stall_cycles < STALL_MAX) @(negedge clock);
      $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
      $display("indexed_singly_linked_list_test NOT OK");
      $finish;
   end

   // Edge cases on a short list
   task automatic test_directed();
      send_op(isll_pkg::OP_GET, 8'd0, 8'd0, 8'd0);
      send_op(isll_pkg::OP_GET, 8'd0, 8'd0, 8'd1);
      send_op(isll_pkg::OP_REMOVE, 8'd0, 8'd0, 8'd0);
      send_op(isll_pkg::OP_CLEAR, 8'd0, 8'd0, 8'd0);
      send_op(isll_pkg::OP_INSERT, 8'd0, 8'd0, 8'd0);
      send_op(isll_pkg::OP_INSERT, 8'd5, 8'd0, 8'd0);
      send_op(isll_pkg::OP_INSERT, 8'd5, 8'd0, 8'd0);
      send_op(isll_pkg::OP_INSERT, 8'd7, 8'd9, 8'd0);
      send_op(isll_pkg::OP_INSERT, 8'd255, 8'd5, 8'd0);
      send_op(isll_pkg::OP_INSERT, 8'd1, 8'd0, 8'd255);
      send_op(isll_pkg::OP_INSERT, 8'd9, 8'd255, 8'd0);
      send_op(isll_pkg::OP_INSERT, 8'd128, 8'd5, 8'd0);
      for (int p = 0; p <= 6; p++)
         send_op(isll_pkg::OP_GET, 8'hff, 8'hff, isll_pkg::item_type'(p));
      send_op(isll_pkg::OP_GET, 8'd0, 8'd0, 8'd255);
      send_op(isll_pkg::OP_REMOVE, 8'd9, 8'd0, 8'd0);
      send_op(isll_pkg::OP_REMOVE, 8'd200, 8'd0, 8'd0);
      send_op(isll_pkg::OP_REMOVE, 8'd0, 8'd0, 8'd0);
      send_op(isll_pkg::OP_REMOVE, 8'd5, 8'd0, 8'd0);
      send_op(isll_pkg::OP_REMOVE, 8'd255, 8'd0, 8'd0);
      send_op(isll_pkg::OP_CLEAR, 8'hff, 8'hff, 8'hff);
      send_op(isll_pkg::OP_CLEAR, 8'd0, 8'd0, 8'd0);
   endtask

   // Fill every item slot, walk the full length, then clear
   task automatic test_full_list();
      for (int i = 1; i <= 255; i++) begin
         if ($urandom_range(0, 3) == 0)
            send_op(isll_pkg::OP_INSERT, isll_pkg::item_type'(i), 8'd0, 8'd0);
         else
            send_op(isll_pkg::OP_INSERT, isll_pkg::item_type'(i), pick_member(), 8'd0);
      end
      send_op(isll_pkg::OP_INSERT, pick_member(), 8'd0, 8'd0);
      send_op(isll_pkg::OP_REMOVE, shadow_tail, 8'd0, 8'd0);
      send_op(isll_pkg::OP_GET, 8'd0, 8'd0, 8'd255);
      send_op(isll_pkg::OP_GET, 8'd0, 8'd0, 8'd254);
      send_op(isll_pkg::OP_REMOVE, 8'd0, 8'd0, 8'd0);
      send_op(isll_pkg::OP_GET, 8'd0, 8'd0, 8'd255);
      send_op(isll_pkg::OP_CLEAR, 8'd0, 8'd0, 8'd0);
   endtask

   // Alternate growing and shrinking phases of mostly well-formed commands
   task automatic test_random();
      int                 r;
      bit                 grow;
      isll_pkg::item_type it;
      isll_pkg::item_type aft;
      isll_pkg::item_type pos;
      logic [1:0]         op;
      for (int n = 0; n < N_RANDOM; n++) begin
         idle_on = !(n >= 400 && n < 550);
         grow = ((n / 150) % 2) == 0;
         r = $urandom_range(0, 99);
         it = isll_pkg::item_type'($urandom_range(0, 255));
         aft = isll_pkg::item_type'($urandom_range(0, 255));
         pos = isll_pkg::item_type'($urandom_range(0, 255));
         if (grow)
            op = (r < 60) ? isll_pkg::OP_INSERT : (r < 75) ? isll_pkg::OP_REMOVE :
                 isll_pkg::OP_GET;
         else
            op = (r < 20) ? isll_pkg::OP_INSERT : (r < 65) ? isll_pkg::OP_REMOVE :
                 (r < 98) ? isll_pkg::OP_GET : isll_pkg::OP_CLEAR;
         case (op)
            isll_pkg::OP_INSERT: begin
               if ($urandom_range(0, 99) < 85) begin
                  it = pick_free();
                  aft = ($urandom_range(0, 3) == 0) ? 8'd0 : pick_member();
               end
            end
            isll_pkg::OP_REMOVE: begin
               if ($urandom_range(0, 99) < 80)
                  it = ($urandom_range(0, 4) == 0) ? 8'd0 : pick_member();
            end
            isll_pkg::OP_GET: begin
               r = $urandom_range(0, 9);
               if (r < 6) pos = isll_pkg::item_type'($urandom_range(0, shadow_len + 1));
               else if (r < 7) pos = isll_pkg::item_type'(shadow_len);
            end
            default: ;
         endcase
         send_op(op, it, aft, pos);
      end
      idle_on = 1'b1;
   endtask

   initial begin
      for (int i = 0; i < 4; i++) op_count[i] = 0;
      void'(apply_list_op(isll_pkg::OP_CLEAR, 8'd0, 8'd0, 8'd0));
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_list();
      test_random();
      // Drain outstanding results, then watch for stray strobes
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Sent %0d inserts, %0d removes, %0d gets, %0d clears; %0d results checked",
               op_count[isll_pkg::OP_INSERT], op_count[isll_pkg::OP_REMOVE],
               op_count[isll_pkg::OP_GET], op_count[isll_pkg::OP_CLEAR], checked);
      $display("Covered empty, full and random-length lists with refused and accepted edits");
      if (fail_count == 0 && expected_q.size() == 0) begin
         $display("indexed_singly_linked_list_test OK");
      end else begin
         $display("indexed_singly_linked_list_test NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> indexed_singly_linked_list.f
src/isll_pkg.sv
src/isll_succ_mem.sv
src/indexed_singly_linked_list.sv
bench/indexed_singly_linked_list_test.sv
